[rtl/assert_macros.svh]
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tccw_pkg.sv]
// Shared types, codes and constants of the text console character writer.
package tccw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 16;
  localparam int ATTR_W = 8;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int TAB_STEP    = 8;
  localparam int QDEPTH      = 2;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_LAST  = 8'h7F;
  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;

  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
  localparam logic [KIND_W-1:0] K_PRINT = 3'd1;
  localparam logic [KIND_W-1:0] K_BS    = 3'd2;
  localparam logic [KIND_W-1:0] K_TAB   = 3'd3;
  localparam logic [KIND_W-1:0] K_CR    = 3'd4;
  localparam logic [KIND_W-1:0] K_LF    = 3'd5;
  localparam logic [KIND_W-1:0] K_CLEAR = 3'd6;
  localparam logic [KIND_W-1:0] K_READ  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
  } cmd_t;

endpackage

[rtl/tccw_req_if.sv]
// Request channel carrying one console operation per item.
interface tccw_req_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, operation, character, read_row, read_col, input ready);
  modport sink (input valid, operation, character, read_row, read_col, output ready);
endinterface

[rtl/tccw_rsp_if.sv]
// Response channel carrying one result item per operation.
interface tccw_rsp_if import tccw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] cursor_position;
  logic             cell_written;
  logic [POS_W-1:0] written_address;
  logic [VAL_W-1:0] written_value;
  logic             scrolled;
  logic [VAL_W-1:0] read_value;

  modport source (output valid, cursor_position, cell_written, written_address,
                  written_value, scrolled, read_value, input ready);
  modport sink (input valid, cursor_position, cell_written, written_address,
                written_value, scrolled, read_value, output ready);
endinterface

[rtl/tccw_cfg_if.sv]
// Configuration write channel for the text attribute register.
interface tccw_cfg_if import tccw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/text_console_character_writer.sv]
// Top level of the text console character writer.
// A put or ignored item gives its result through the output register once it heads the queue, a
// read through the RAM read register and the read state, a scroll after its row fill and a clear
// after the whole RAM fill. Throughput: one put per cycle while the receiver takes results and no
// read, scroll or clear stalls the back end. Reset (synchronous, active high) blanks the RAM with
// attribute 0x0F; no item is taken during it, configuration writes are.
`include "assert_macros.svh"

module text_console_character_writer import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic      clk,
  input logic      rst,
  tccw_req_if.sink req,
  tccw_rsp_if.source rsp,
  tccw_cfg_if.sink cfg
);

  logic [ATTR_W-1:0] attr;
  logic              init;
  logic              push;
  cmd_t              push_cmd;
  logic              full;
  logic              q_pop;
  logic              q_valid;
  cmd_t              q_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg.valid && cfg.ready) begin
      attr <= cfg.data;
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req      (req),
    .init     (init),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tccw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .attr    (attr),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .init    (init),
    .rsp     (rsp)
  );

  `ASSERT_SAME(a_init_no_pop, clk, rst, init, !q_pop && !push, "item taken during the reset fill")
  `ASSERT_SAME(a_pop_nonempty, clk, rst, q_pop, q_valid, "command taken from an empty queue")
  `ASSERT_SAME(a_written_printable, clk, rst, rsp.valid && rsp.cell_written, (rsp.written_value[7:5] != 3'b000) && !rsp.written_value[7], "stored byte is not printable")
  `ASSERT_SAME(a_unwritten_zero, clk, rst, rsp.valid && !rsp.cell_written, rsp.written_address == '0 && rsp.written_value == '0, "write fields set without a store")

endmodule

[rtl/tccw_front.sv]
// Front end: accepts request items and classifies them into commands.
module tccw_front import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  tccw_req_if.sink req,
  input  logic     init,
  input  logic     full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic in_range;

  assign req.ready = !full && !init;
  assign push      = req.valid && req.ready;
  assign in_range  = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);

  always_comb begin
    push_cmd.character = req.character;
    push_cmd.rd_row    = req.read_row;
    push_cmd.rd_col    = req.read_col;
    push_cmd.kind      = K_NOP;
    case (req.operation)
      OP_PUT: begin
        case (req.character)
          CH_BS:   push_cmd.kind = K_BS;
          CH_TAB:  push_cmd.kind = K_TAB;
          CH_CR:   push_cmd.kind = K_CR;
          CH_LF:   push_cmd.kind = K_LF;
          default: begin
            if (req.character >= BLANK_CHAR && req.character <= PRINT_LAST) begin
              push_cmd.kind = K_PRINT;
            end
          end
        endcase
      end
      OP_CLEAR: push_cmd.kind = K_CLEAR;
      OP_READ:  push_cmd.kind = in_range ? K_READ : K_NOP;
      default:  push_cmd.kind = K_NOP;
    endcase
  end

endmodule

[rtl/tccw_fifo.sv]
// Short command queue between the front end and the back end.
module tccw_fifo import tccw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t          entries [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;

  assign full    = count == NW'(QDEPTH);
  assign valid   = count != '0;
  assign pop_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tccw_back.sv]
// Back end: cursor, cell memory with rotating row origin, fills and results.
module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] attr,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              init,
  tccw_rsp_if.source        rsp
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CNW   = $clog2(COLUMNS + TAB_STEP);
  localparam int RW    = $clog2(ROWS);
  localparam int RNW   = $clog2(ROWS + 1);
  localparam int PW    = (AW > POS_W) ? AW : POS_W;

  localparam logic [1:0] S_FILL = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [VAL_W-1:0] mem [CELLS];

  logic [1:0]       state;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [RW-1:0]    top;
  logic [AW-1:0]    fill_addr;
  logic [AW-1:0]    fill_end;
  logic [VAL_W-1:0] fill_value;
  logic             pend_active;
  logic             pend_written;
  logic [POS_W-1:0] pend_waddr;
  logic [VAL_W-1:0] pend_wval;
  logic             pend_scrolled;
  logic [VAL_W-1:0] rd_data;

  logic             o_valid;
  logic [POS_W-1:0] o_cursor;
  logic             o_written;
  logic [POS_W-1:0] o_waddr;
  logic [VAL_W-1:0] o_wval;
  logic             o_scrolled;
  logic [VAL_W-1:0] o_read;

  logic             out_free;
  logic [CNW-1:0]   col_n;
  logic [RNW-1:0]   row_n;
  logic             need_scroll;
  logic [CW-1:0]    col_f;
  logic [RW-1:0]    row_f;
  logic [RW-1:0]    top_inc;
  logic [AW-1:0]    scroll_base;
  logic [VAL_W-1:0] print_value;
  logic [VAL_W-1:0] blank_value;
  logic             fill_done;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [VAL_W-1:0] mem_wd;
  logic             rd_en;
  logic [AW-1:0]    rd_a;
  logic             emit;
  logic [POS_W-1:0] e_cursor;
  logic             e_written;
  logic [POS_W-1:0] e_waddr;
  logic [VAL_W-1:0] e_wval;
  logic             e_scrolled;
  logic [VAL_W-1:0] e_read;

  function automatic logic [POS_W-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [PW-1:0] s;
    s = PW'(r) * PW'(COLUMNS) + PW'(c);
    return s[POS_W-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] t,
                                              input logic [CW-1:0] c);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (RW + 1)'(ROWS)) begin
      s = s - (RW + 1)'(ROWS);
    end
    return AW'(s[RW-1:0]) * AW'(COLUMNS) + AW'(c);
  endfunction

  assign init        = state == S_FILL && !pend_active;
  assign out_free    = !o_valid || rsp.ready;
  assign q_pop       = state == S_RUN && q_valid && out_free;
  assign print_value = {attr, q_cmd.character};
  assign blank_value = {attr, BLANK_CHAR};
  assign fill_done   = fill_addr == fill_end;
  assign top_inc     = (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
  assign scroll_base = AW'(top) * AW'(COLUMNS);

  always_comb begin
    col_n = CNW'(col);
    row_n = RNW'(row);
    case (q_cmd.kind)
      K_PRINT: col_n = CNW'(col) + 1'b1;
      K_BS: begin
        if (col != '0) begin
          col_n = CNW'(col) - 1'b1;
        end
      end
      K_TAB: col_n = (CNW'(col) + CNW'(TAB_STEP)) & ~CNW'(TAB_STEP - 1);
      K_CR:  col_n = '0;
      K_LF: begin
        col_n = '0;
        row_n = RNW'(row) + 1'b1;
      end
      default: ;
    endcase
    if (col_n >= CNW'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end
    need_scroll = row_n >= RNW'(ROWS);
    col_f = CW'(col_n);
    row_f = need_scroll ? RW'(ROWS - 1) : RW'(row_n);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_addr;
    mem_wd = fill_value;
    if (state == S_FILL) begin
      mem_we = 1'b1;
    end else if (q_pop && q_cmd.kind == K_PRINT) begin
      mem_we = 1'b1;
      mem_wa = cell_addr(row, top, col);
      mem_wd = print_value;
    end
    rd_en = q_pop && q_cmd.kind == K_READ;
    rd_a  = cell_addr(RW'(q_cmd.rd_row), top, CW'(q_cmd.rd_col));
  end

  always_comb begin
    emit       = 1'b0;
    e_cursor   = lin(row, col);
    e_written  = 1'b0;
    e_waddr    = '0;
    e_wval     = '0;
    e_scrolled = 1'b0;
    e_read     = '0;
    case (state)
      S_RUN: begin
        if (q_pop && q_cmd.kind != K_CLEAR && q_cmd.kind != K_READ && !need_scroll) begin
          emit     = 1'b1;
          e_cursor = lin(row_f, col_f);
          if (q_cmd.kind == K_PRINT) begin
            e_written = 1'b1;
            e_waddr   = lin(row, col);
            e_wval    = print_value;
          end
        end
      end
      S_FILL: begin
        if (fill_done && pend_active) begin
          emit       = 1'b1;
          e_written  = pend_written;
          e_waddr    = pend_waddr;
          e_wval     = pend_wval;
          e_scrolled = pend_scrolled;
        end
      end
      S_READ: begin
        emit   = 1'b1;
        e_read = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_cursor   <= e_cursor;
      o_written  <= e_written;
      o_waddr    <= e_waddr;
      o_wval     <= e_wval;
      o_scrolled <= e_scrolled;
      o_read     <= e_read;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_written  <= q_cmd.kind == K_PRINT;
      pend_waddr    <= (q_cmd.kind == K_PRINT) ? lin(row, col) : '0;
      pend_wval     <= (q_cmd.kind == K_PRINT) ? print_value : '0;
      pend_scrolled <= q_cmd.kind != K_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      pend_active <= 1'b0;
      fill_addr   <= '0;
      fill_end    <= AW'(CELLS - 1);
      fill_value  <= {RESET_ATTR, BLANK_CHAR};
      col         <= '0;
      row         <= '0;
      top         <= '0;
      o_valid     <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          if (fill_done) begin
            state       <= S_RUN;
            pend_active <= 1'b0;
          end else begin
            fill_addr <= fill_addr + 1'b1;
          end
        end
        S_READ: state <= S_RUN;
        S_RUN: begin
          if (q_pop) begin
            case (q_cmd.kind)
              K_CLEAR: begin
                col         <= '0;
                row         <= '0;
                top         <= '0;
                fill_addr   <= '0;
                fill_end    <= AW'(CELLS - 1);
                fill_value  <= blank_value;
                pend_active <= 1'b1;
                state       <= S_FILL;
              end
              K_READ: state <= S_READ;
              default: begin
                col <= col_f;
                row <= row_f;
                if (need_scroll) begin
                  top         <= top_inc;
                  fill_addr   <= scroll_base;
                  fill_end    <= scroll_base + AW'(COLUMNS - 1);
                  fill_value  <= blank_value;
                  pend_active <= 1'b1;
                  state       <= S_FILL;
                end
              end
            endcase
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  assign rsp.valid           = o_valid;
  assign rsp.cursor_position = o_cursor;
  assign rsp.cell_written    = o_written;
  assign rsp.written_address = o_waddr;
  assign rsp.written_value   = o_wval;
  assign rsp.scrolled        = o_scrolled;
  assign rsp.read_value      = o_read;

endmodule

[tb/tb_text_console_character_writer.sv]
// Self-checking testbench for the text console character writer.
`timescale 1ns / 100ps

module tb_text_console_character_writer import tccw_pkg::*; ();

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic cell_written;
    logic [POS_W-1:0] written_address;
    logic [VAL_W-1:0] written_value;
    logic scrolled;
    logic [VAL_W-1:0] read_value;
  } console_result_t;

  logic clk;
  logic rst;

  tccw_req_if req_if ();
  tccw_rsp_if rsp_if ();
  tccw_cfg_if cfg_if ();

  text_console_character_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  logic [VAL_W-1:0] screen_model [0:CELLS-1];
  logic [ATTR_W-1:0] attr_model;
  int cur_col;
  int cur_row;

  console_result_t pending_results[$];
  int error_count = 0;
  int item_count = 0;
  int result_count = 0;
  int stored_count = 0;
  int scroll_count = 0;
  int read_count = 0;
  int clear_count = 0;
  int attr_count = 0;
  int stall_cycles = 0;
  int rsp_hold_cycles = 0;
  bit req_no_gaps = 0;
  bit rsp_no_gaps = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void blank_screen(int first);
    for (int i = first; i < CELLS; i++) begin
      screen_model[i] = {attr_model, BLANK_CHAR};
    end
  endfunction

  function automatic console_result_t predict_console(logic [OP_W-1:0] op,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [ROW_W-1:0] row,
                                                      logic [COL_W-1:0] col);
    console_result_t res;
    int addr;
    res = '0;
    if (op == OP_PUT) begin
      if (ch == CH_BS) begin
        if (cur_col != 0) cur_col--;
      end else if (ch == CH_TAB) begin
        cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else if (ch == CH_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (ch >= BLANK_CHAR && ch <= PRINT_LAST) begin
        addr = cur_row * COLUMNS + cur_col;
        res.cell_written = 1'b1;
        res.written_address = addr[POS_W-1:0];
        res.written_value = {attr_model, ch};
        screen_model[addr] = {attr_model, ch};
        cur_col++;
        stored_count++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
          screen_model[i] = screen_model[i + COLUMNS];
        end
        blank_screen(CELLS - COLUMNS);
        cur_row = ROWS - 1;
        res.scrolled = 1'b1;
        scroll_count++;
      end
    end else if (op == OP_CLEAR) begin
      blank_screen(0);
      cur_col = 0;
      cur_row = 0;
      clear_count++;
    end else if (op == OP_READ) begin
      if (row < ROWS && col < COLUMNS) begin
        res.read_value = screen_model[row * COLUMNS + col];
      end
      read_count++;
    end
    addr = cur_row * COLUMNS + cur_col;
    res.cursor_position = addr[POS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", result_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want != got) begin
      report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  task automatic send_console_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                   input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col);
    int gap;
    gap = req_no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.character <= ch;
    req_if.read_row <= row;
    req_if.read_col <= col;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_console(op, ch, row, col));
    item_count++;
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_console_item(OP_PUT, ch, ROW_W'($urandom_range(0, 31)),
                      COL_W'($urandom_range(0, 127)));
  endtask

  task automatic send_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_console_item(OP_READ, CHAR_W'($urandom_range(0, 255)), row, col);
  endtask

  task automatic send_random_item();
    int pick;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      send_console_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    end else if (pick < 13) begin
      send_console_item(2'd3, CHAR_W'($urandom_range(0, 255)),
                        ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    end else if (pick < 153) begin
      case ($urandom_range(0, 7))
        0: begin
          row = ROW_W'($urandom_range(0, 31));
          col = COL_W'($urandom_range(0, 127));
        end
        1, 2, 3: begin
          row = ROW_W'(cur_row);
          col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        default: begin
          row = ROW_W'($urandom_range(0, ROWS - 1));
          col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
      endcase
      send_read(row, col);
    end else if (pick < 303) begin
      send_put(CH_LF);
    end else if (pick < 383) begin
      send_put(CH_TAB);
    end else if (pick < 423) begin
      send_put(CH_CR);
    end else if (pick < 473) begin
      send_put(CH_BS);
    end else if (pick < 523) begin
      if ($urandom_range(0, 1) == 0) begin
        ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
      end else begin
        do ch = CHAR_W'($urandom_range(0, 8'h1F));
        while (ch == CH_BS || ch == CH_TAB || ch == CH_CR || ch == CH_LF);
      end
      send_put(ch);
    end else begin
      send_put(CHAR_W'($urandom_range(BLANK_CHAR, PRINT_LAST)));
    end
  endtask

  task automatic wait_console_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    attr_model = value;
    attr_count++;
  endtask

  // Reads across the reset contents, out-of-range reads and the unused operation.
  task automatic test_reset_state();
    send_read('0, '0);
    send_read(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    send_read(ROW_W'(ROWS), '0);
    send_read('0, COL_W'(COLUMNS));
    send_read(5'd31, 7'd127);
    send_console_item(2'd3, 8'hFF, 5'd31, 7'd127);
  endtask

  // Printable bytes, every handled control byte, ignored bytes and clear.
  task automatic test_put_and_controls();
    send_put(8'h41);
    send_put(BLANK_CHAR);
    send_put(PRINT_LAST);
    repeat (4) send_put(CH_BS);
    send_put(CH_TAB);
    send_put(CH_CR);
    send_put(CH_LF);
    send_put(8'h00);
    send_put(8'h1F);
    send_put(8'h80);
    send_put(8'hFF);
    send_read('0, '0);
    send_console_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_read('0, 7'd2);
  endtask

  task automatic test_attribute_phases();
    logic [ATTR_W-1:0] settings [5];
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = 8'hA5;
    settings[3] = ATTR_W'($urandom_range(0, 255));
    settings[4] = RESET_ATTR;
    foreach (settings[i]) begin
      wait_console_idle();
      write_attribute(settings[i]);
      repeat (PHASE_ITEMS) send_random_item();
    end
    wait_console_idle();
  endtask

  // The receiver stalls for a long stretch while items keep coming.
  task automatic test_output_backpressure();
    req_no_gaps = 1;
    rsp_hold_cycles = 300;
    repeat (60) send_random_item();
    req_no_gaps = 0;
    wait_console_idle();
  endtask

  task automatic test_back_to_back();
    req_no_gaps = 1;
    rsp_no_gaps = 1;
    repeat (200) send_random_item();
    req_no_gaps = 0;
    rsp_no_gaps = 0;
    wait_console_idle();
  endtask

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = rsp_no_gaps ? 0 : $urandom_range(0, 9);
      if (rsp_hold_cycles > 0) begin
        stall = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with none outstanding");
      end else begin
        console_result_t want;
        want = pending_results.pop_front();
        check_field("cursor_position", VAL_W'(want.cursor_position),
                    VAL_W'(rsp_if.cursor_position));
        check_field("cell_written", VAL_W'(want.cell_written), VAL_W'(rsp_if.cell_written));
        check_field("written_address", VAL_W'(want.written_address),
                    VAL_W'(rsp_if.written_address));
        check_field("written_value", want.written_value, rsp_if.written_value);
        check_field("scrolled", VAL_W'(want.scrolled), VAL_W'(rsp_if.scrolled));
        check_field("read_value", want.read_value, rsp_if.read_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.operation <= OP_PUT;
    req_if.character <= '0;
    req_if.read_row <= '0;
    req_if.read_col <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    attr_model = RESET_ATTR;
    cur_col = 0;
    cur_row = 0;
    blank_screen(0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_put_and_controls();
    test_attribute_phases();
    test_output_backpressure();
    test_back_to_back();

    repeat (COLUMNS + 20) @(posedge clk);
    $display("Covered %0d items over %0d attribute settings: %0d stored characters,",
             item_count, attr_count, stored_count);
    $display("%0d scrolls, %0d reads and %0d clears, with stalls on both sides.",
             scroll_count, read_count, clear_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
